/* design/p2g_pkg.sv */
package p2g_pkg;

  localparam int ANG_W = 28;
  localparam int TRIG_W = 33;
  localparam int DEN_W = 30;
  localparam int C16_W = 19;
  localparam int EAST_W = 41;
  localparam int NUM2_W = EAST_W + 16;
  localparam int CORDIC_STEPS = 18;
  localparam int STEP_W = 5;

  localparam logic [2:0] REG_IMAGE_WIDTH = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_GROUND_WIDTH = 3'd2;
  localparam logic [2:0] REG_HEADING = 3'd3;
  localparam logic [2:0] REG_CENTER_LATITUDE = 3'd4;
  localparam logic [2:0] REG_CENTER_LONGITUDE = 3'd5;
  localparam logic [2:0] REG_METERS_PER_DEGREE = 3'd6;

  localparam logic signed [ANG_W-1:0] ANG_FULL = ANG_W'(23592960);
  localparam logic signed [ANG_W-1:0] ANG_HALF = ANG_W'(11796480);
  localparam logic signed [ANG_W-1:0] ANG_QUARTER = ANG_W'(5898240);

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = TRIG_W'(652032874);
  localparam longint ONE_Q30_M1 = 64'd1073741823;
  localparam longint LAT_LIMIT = 64'd1509949440;
  localparam longint LON_LIMIT = 64'd3019898880;
  localparam longint EAST_LIMIT = 64'd1099511627776;
  localparam logic signed [C16_W-1:0] COS_MIN = C16_W'(64);

  typedef struct packed {
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
  } trig_t;

  function automatic logic signed [ANG_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
    logic signed [ANG_W-1:0] v;
    case (i)
      5'd0: v = ANG_W'(2949120);
      5'd1: v = ANG_W'(1740967);
      5'd2: v = ANG_W'(919879);
      5'd3: v = ANG_W'(466945);
      5'd4: v = ANG_W'(234379);
      5'd5: v = ANG_W'(117305);
      5'd6: v = ANG_W'(58666);
      5'd7: v = ANG_W'(29335);
      5'd8: v = ANG_W'(14668);
      5'd9: v = ANG_W'(7334);
      5'd10: v = ANG_W'(3667);
      5'd11: v = ANG_W'(1833);
      5'd12: v = ANG_W'(917);
      5'd13: v = ANG_W'(458);
      5'd14: v = ANG_W'(229);
      5'd15: v = ANG_W'(115);
      5'd16: v = ANG_W'(57);
      5'd17: v = ANG_W'(29);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* design/p2g_cordic.sv */
module p2g_cordic
  import p2g_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [ANG_W-1:0] angle,
  output logic                    done,
  output trig_t                   result
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_WRAP = 3'd1;
  localparam logic [2:0] PH_FOLD = 3'd2;
  localparam logic [2:0] PH_ITER = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  logic [2:0] phase;
  logic [STEP_W-1:0] step;
  logic signed [ANG_W-1:0] z;
  logic signed [TRIG_W-1:0] x;
  logic signed [TRIG_W-1:0] y;
  logic neg;

  logic signed [ANG_W-1:0] a_wrap;
  logic signed [TRIG_W-1:0] dx;
  logic signed [TRIG_W-1:0] dy;
  logic signed [ANG_W-1:0] at;

  always_comb begin
    a_wrap = angle;
    if (angle >= ANG_FULL) begin
      a_wrap = angle - ANG_FULL;
    end else if (angle <= -ANG_FULL) begin
      a_wrap = angle + ANG_FULL;
    end
  end

  assign dx = y >>> step;
  assign dy = x >>> step;
  assign at = atan_q16(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (start) begin
      phase <= PH_WRAP;
    end else begin
      unique case (phase)
        PH_WRAP: phase <= PH_FOLD;
        PH_FOLD: phase <= PH_ITER;
        PH_ITER: begin
          if (step == STEP_W'(CORDIC_STEPS - 1)) begin
            phase <= PH_DONE;
          end
        end
        PH_DONE: phase <= PH_IDLE;
        default: phase <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      z <= a_wrap;
    end else if (phase == PH_WRAP) begin
      if (z >= ANG_HALF) begin
        z <= z - ANG_FULL;
      end else if (z < -ANG_HALF) begin
        z <= z + ANG_FULL;
      end
    end else if (phase == PH_FOLD) begin
      x <= CORDIC_GAIN;
      y <= '0;
      step <= '0;
      neg <= 1'b0;
      if (z > ANG_QUARTER) begin
        z <= z - ANG_HALF;
        neg <= 1'b1;
      end else if (z < -ANG_QUARTER) begin
        z <= z + ANG_HALF;
        neg <= 1'b1;
      end
    end else if (phase == PH_ITER) begin
      step <= step + 1'b1;
      if (!z[ANG_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
    end
  end

  assign done = (phase == PH_DONE);
  assign result.s = neg ? -y : y;
  assign result.c = neg ? -x : x;

endmodule

/* design/p2g_div.sv */
module p2g_div #(
  parameter int NUM_W = 53,
  parameter int DIV_W = 30,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_valid,
  output logic [NUM_W-1:0] quot,
  output logic [TAG_W-1:0] tag_out
);

  logic [DIV_W-1:0] rem [1:NUM_W];
  logic [NUM_W-1:0] nq [1:NUM_W];
  logic             vld [1:NUM_W];
  logic [TAG_W-1:0] tg [1:NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [DIV_W-1:0] r_in;
    logic [NUM_W-1:0] nq_in;
    logic             v_in;
    logic [TAG_W-1:0] t_in;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             take;

    if (i == 0) begin : g_first
      assign r_in = '0;
      assign nq_in = num;
      assign v_in = in_valid;
      assign t_in = tag_in;
    end else begin : g_next
      assign r_in = rem[i];
      assign nq_in = nq[i];
      assign v_in = vld[i];
      assign t_in = tg[i];
    end

    assign trial = {r_in, nq_in[NUM_W-1]};
    assign diff = trial - {1'b0, den};
    assign take = (trial >= {1'b0, den});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= v_in;
      end
      rem[i+1] <= take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      nq[i+1] <= {nq_in[NUM_W-2:0], take};
      tg[i+1] <= t_in;
    end
  end

  assign out_valid = vld[NUM_W];
  assign quot = nq[NUM_W];
  assign tag_out = tg[NUM_W];

endmodule

/* design/pixel_to_gps_position.sv */
// Converts one pixel coordinate per clock while busy is low into latitude and longitude.
// A pixel is transferred when start is high and busy is low; its result appears on the
// output ports with done high for exactly one cycle, after the centering, product, sum,
// rounding, magnitude and scaling registers, the parallel bit-per-stage north and east
// dividers, the latitude sum and clamp registers, the bit-per-stage longitude divider
// and the longitude sum and output registers. A new pixel may follow in every cycle
// while busy is low and results come out in the same order. The receiver cannot stall
// the output. Busy stays high after reset and from every configuration write on, while
// one shared iterative CORDIC unit evaluates the heading and center-latitude cosines.
module pixel_to_gps_position
  import p2g_pkg::*;
#(
  parameter int PIXEL_COORD_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [PIXEL_COORD_BITS-1:0] pixel_x,
  input  logic [PIXEL_COORD_BITS-1:0] pixel_y,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [32:0]                 cfg_data,
  output logic                        done,
  output logic signed [31:0]          out_latitude,
  output logic signed [32:0]          out_longitude,
  output logic                        out_of_range
);

  localparam int CW = (PIXEL_COORD_BITS > 12 ? PIXEL_COORD_BITS : 12) + 1;
  localparam int RW = CW + 1;
  localparam int PW = CW + TRIG_W;
  localparam int SW = PW + 1;
  localparam int NUM_W = CW + 40;
  localparam int LSW = NUM_W + 2;
  localparam int OSW = NUM2_W + 2;

  localparam logic [1:0] SQ_READY = 2'd0;
  localparam logic [1:0] SQ_KICK = 2'd1;
  localparam logic [1:0] SQ_HEAD = 2'd2;
  localparam logic [1:0] SQ_LAT = 2'd3;

  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [31:0] ground_width;
  logic signed [17:0] heading;
  logic signed [31:0] center_latitude;
  logic signed [32:0] center_longitude;
  logic [16:0] meters_per_degree;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 13'd1920;
      image_height <= 13'd1080;
      ground_width <= 32'd6553600;
      heading <= '0;
      center_latitude <= '0;
      center_longitude <= '0;
      meters_per_degree <= 17'd111320;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: image_width <= cfg_data[12:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
        REG_GROUND_WIDTH: ground_width <= cfg_data[31:0];
        REG_HEADING: heading <= cfg_data[17:0];
        REG_CENTER_LATITUDE: center_latitude <= cfg_data[31:0];
        REG_CENTER_LONGITUDE: center_longitude <= cfg_data[32:0];
        REG_METERS_PER_DEGREE: meters_per_degree <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  logic [1:0] seq;
  logic cstart;
  logic cdone;
  logic signed [ANG_W-1:0] cangle;
  trig_t ctrig;
  logic signed [TRIG_W-1:0] sin_h;
  logic signed [TRIG_W-1:0] cos_h;
  logic signed [C16_W-1:0] c16;
  logic [DEN_W-1:0] den;
  logic polar;

  assign cstart = (seq == SQ_KICK) || ((seq == SQ_HEAD) && cdone);
  assign cangle = (seq == SQ_KICK) ? ANG_W'($signed({heading, 8'd0}))
                                   : ANG_W'($signed(center_latitude[31:8]));

  p2g_cordic u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cstart),
    .angle  (cangle),
    .done   (cdone),
    .result (ctrig)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= SQ_KICK;
    end else if (cfg_we) begin
      seq <= SQ_KICK;
    end else begin
      unique case (seq)
        SQ_KICK: seq <= SQ_HEAD;
        SQ_HEAD: begin
          if (cdone) begin
            seq <= SQ_LAT;
          end
        end
        SQ_LAT: begin
          if (cdone) begin
            seq <= SQ_READY;
          end
        end
        default: seq <= SQ_READY;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((seq == SQ_HEAD) && cdone) begin
      sin_h <= ctrig.s;
      cos_h <= ctrig.c;
    end
    if ((seq == SQ_LAT) && cdone) begin
      c16 <= C16_W'(ctrig.c >>> 14);
    end
    den <= {17'd0, (image_width == '0 ? 13'd1 : image_width)}
           * {13'd0, (meters_per_degree == '0 ? 17'd1 : meters_per_degree)};
  end

  assign polar = (c16 < COS_MIN);
  assign busy = (seq != SQ_READY) || cfg_we;

  logic v1, v2, v3, v4, v5, v6;
  logic signed [CW-1:0] cx, cy;
  logic signed [PW-1:0] p_xc, p_ys, p_yc, p_xs;
  logic signed [SW-1:0] sx, sy;
  logic signed [SW-1:0] bx, by;
  logic signed [RW-1:0] rx, ry;
  logic [CW-1:0] ax, ay;
  logic sgx5, sgy5, sgx6, sgy6;
  logic [CW+31:0] mx, my;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  assign bx = sx + (sx[SW-1] ? SW'(ONE_Q30_M1) : SW'(0));
  assign by = sy + (sy[SW-1] ? SW'(ONE_Q30_M1) : SW'(0));

  always_ff @(posedge clk) begin
    cx <= $signed({{(CW-PIXEL_COORD_BITS){1'b0}}, pixel_x})
          - $signed({{(CW-12){1'b0}}, image_width[12:1]});
    cy <= $signed({{(CW-12){1'b0}}, image_height[12:1]})
          - $signed({{(CW-PIXEL_COORD_BITS){1'b0}}, pixel_y});
    p_xc <= cx * cos_h;
    p_ys <= cy * sin_h;
    p_yc <= cy * cos_h;
    p_xs <= cx * sin_h;
    sx <= SW'(p_xc) + SW'(p_ys);
    sy <= SW'(p_yc) - SW'(p_xs);
    rx <= RW'(bx >>> 30);
    ry <= RW'(by >>> 30);
    ax <= rx[RW-1] ? CW'(-rx) : CW'(rx);
    ay <= ry[RW-1] ? CW'(-ry) : CW'(ry);
    sgx5 <= rx[RW-1];
    sgy5 <= ry[RW-1];
    mx <= ax * ground_width;
    my <= ay * ground_width;
    sgx6 <= sgx5;
    sgy6 <= sgy5;
  end

  logic dv_n, dv_e;
  logic [NUM_W-1:0] qn, qe;
  logic sgn_n, sgn_e;

  p2g_div #(.NUM_W(NUM_W), .DIV_W(DEN_W), .TAG_W(1)) u_div_north (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v6),
    .num       ({my, 8'd0}),
    .den       (den),
    .tag_in    (sgy6),
    .out_valid (dv_n),
    .quot      (qn),
    .tag_out   (sgn_n)
  );

  p2g_div #(.NUM_W(NUM_W), .DIV_W(DEN_W), .TAG_W(1)) u_div_east (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v6),
    .num       ({mx, 8'd0}),
    .den       (den),
    .tag_in    (sgx6),
    .out_valid (dv_e),
    .quot      (qe),
    .tag_out   (sgn_e)
  );

  logic v7, v8, v9;
  logic signed [LSW-1:0] lat_sum;
  logic [EAST_W-1:0] em7, em8;
  logic se7, se8;
  logic signed [31:0] lat8;
  logic lf8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else begin
      v7 <= dv_n && dv_e;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    lat_sum <= sgn_n ? LSW'(center_latitude) - $signed({2'b00, qn})
                     : LSW'(center_latitude) + $signed({2'b00, qn});
    em7 <= (LSW'(qe) > LSW'(EAST_LIMIT)) ? EAST_W'(EAST_LIMIT) : qe[EAST_W-1:0];
    se7 <= sgn_e;
    em8 <= em7;
    se8 <= se7;
    lf8 <= 1'b0;
    lat8 <= lat_sum[31:0];
    if (lat_sum > LSW'(LAT_LIMIT)) begin
      lat8 <= 32'(LAT_LIMIT);
      lf8 <= 1'b1;
    end else if (lat_sum < -LSW'(LAT_LIMIT)) begin
      lat8 <= -32'(LAT_LIMIT);
      lf8 <= 1'b1;
    end
  end

  logic dv2;
  logic [NUM2_W-1:0] q2;
  logic [33:0] tag2;
  logic signed [OSW-1:0] lon_sum;
  logic signed [31:0] lat9;
  logic lf9;
  logic signed [OSW-1:0] clon_x;

  p2g_div #(.NUM_W(NUM2_W), .DIV_W(C16_W-2), .TAG_W(34)) u_div_lon (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v8),
    .num       ({em8, 16'd0}),
    .den       (c16[C16_W-3:0]),
    .tag_in    ({lat8, lf8, se8}),
    .out_valid (dv2),
    .quot      (q2),
    .tag_out   (tag2)
  );

  assign clon_x = OSW'(center_longitude);

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
      done <= 1'b0;
    end else begin
      v9 <= dv2;
      done <= v9;
    end
  end

  always_ff @(posedge clk) begin
    lon_sum <= tag2[0] ? clon_x - $signed({2'b00, q2}) : clon_x + $signed({2'b00, q2});
    lat9 <= tag2[33:2];
    lf9 <= tag2[1];
    out_latitude <= lat9;
    if (polar) begin
      out_of_range <= 1'b1;
      if (clon_x > OSW'(LON_LIMIT)) begin
        out_longitude <= 33'(LON_LIMIT);
      end else if (clon_x < -OSW'(LON_LIMIT)) begin
        out_longitude <= -33'(LON_LIMIT);
      end else begin
        out_longitude <= center_longitude;
      end
    end else if (lon_sum > OSW'(LON_LIMIT)) begin
      out_longitude <= 33'(LON_LIMIT);
      out_of_range <= 1'b1;
    end else if (lon_sum < -OSW'(LON_LIMIT)) begin
      out_longitude <= -33'(LON_LIMIT);
      out_of_range <= 1'b1;
    end else begin
      out_longitude <= lon_sum[32:0];
      out_of_range <= lf9;
    end
  end

endmodule

/* design/p2g_checker.sv */
module p2g_checker
  import p2g_pkg::*;
#(
  parameter int PIXEL_COORD_BITS = 12
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic [PIXEL_COORD_BITS-1:0] pixel_x,
  input logic [PIXEL_COORD_BITS-1:0] pixel_y,
  input logic                        cfg_we,
  input logic [2:0]                  cfg_index,
  input logic [32:0]                 cfg_data,
  input logic                        done,
  input logic signed [31:0]          out_latitude,
  input logic signed [32:0]          out_longitude,
  input logic                        out_of_range
);

  a_busy_after_write: assert property (@(posedge clk) disable iff (rst) cfg_we |=> busy)
    else $error("busy low right after a configuration write");

  a_reset_quiet: assert property (@(posedge clk) rst |=> busy && !done)
    else $error("block not quiet and busy after reset");

  a_lat_range: assert property (@(posedge clk) disable iff (rst)
      done |-> (out_latitude <= 32'sd1509949440) && (out_latitude >= -32'sd1509949440))
    else $error("latitude transfer outside range");

  a_lon_range: assert property (@(posedge clk) disable iff (rst)
      done |-> (out_longitude <= 33'sd3019898880) && (out_longitude >= -33'sd3019898880))
    else $error("longitude transfer outside range");

endmodule

bind pixel_to_gps_position p2g_checker #(.PIXEL_COORD_BITS(PIXEL_COORD_BITS)) u_p2g_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .pixel_x       (pixel_x),
  .pixel_y       (pixel_y),
  .cfg_we        (cfg_we),
  .cfg_index     (cfg_index),
  .cfg_data      (cfg_data),
  .done          (done),
  .out_latitude  (out_latitude),
  .out_longitude (out_longitude),
  .out_of_range  (out_of_range)
);
